// File: rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro samples on clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent true -> consequent holds at the same edge
`define ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent true -> consequent holds at the next edge
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/rsa_mexp_pkg.sv
// Shared constants and types for the modular exponentiation core.
// No dependencies.
package rsa_mexp_pkg;

   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS          = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PUBLIC_EXPONENT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIVATE_EXPONENT = 2'd2;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   // largest result width carried on the response
   localparam int RESULT_MAX_W = 32;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

endpackage

// File: rtl/core/rsa_mexp_modmul.sv
// Bit-serial modular multiplier: (a * b) mod n, one bit of b per cycle, MSB first.
// Depends on rsa_mexp_pkg.
module rsa_mexp_modmul #(
   parameter int WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [WIDTH-1:0]            a,
   input  logic [WIDTH-1:0]            b,
   input  logic [WIDTH-1:0]            n,
   output rsa_mexp_pkg::mul_status_type status,
   output logic [WIDTH-1:0]            product
);
   import rsa_mexp_pkg::*;

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH-1:0] dbl;

   // (x + y) mod m for x, y below m
   function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
      logic [WIDTH:0] s;
      logic [WIDTH:0] t;
      s = {1'b0, x} + {1'b0, y};
      t = s - {1'b0, m};
      return t[WIDTH] ? s[WIDTH-1:0] : t[WIDTH-1:0];
   endfunction

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      dbl     = add_mod(acc_ff, acc_ff, n);
      if (start) begin
         acc_in  = '0;
         a_in    = a;
         b_in    = b;
         cnt_in  = CNT_W'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = b_ff[WIDTH-1] ? add_mod(dbl, a_ff, n) : dbl;
         b_in   = {b_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = acc_ff;

endmodule

// File: rtl/core/rsa_modular_exponentiation_core.sv
// Modular exponentiation core: result = message ^ exponent mod modulus.
// Depends on rsa_mexp_pkg and rsa_mexp_modmul.
//
// Usage:
//   csr_we/csr_index/csr_wdata load modulus (0), public exponent (1) and
//   private exponent (2); write only while the core is idle.
//   Request item: req_tdata = message value, req_tuser = op (0 encrypt with
//   the public exponent, 1 decrypt with the private exponent).
//   Response item: rsp_tdata = result value.
// Operation:
//   Square and multiply over all WIDTH exponent bits, MSB first; each modular
//   multiply runs through start, WIDTH steps and a hand-off. One item at a
//   time: req_tready returns with rsp_tvalid; a modulus of zero skips the
//   multiplies and returns 0 through S_OUT.
// Reset: clears control state; registers return to modulus 1, exponents 0.
// Stall: the response is held in an output register; the core accepts the
// next item while it waits, and a finished result waits in the core until
// the register frees up.
module rsa_modular_exponentiation_core #(
   parameter int WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((WIDTH+7)/8)*8-1:0]           req_tdata,   // [WIDTH-1:0] message_value
   input  logic                                 req_tuser,   // [0] op
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((WIDTH+7)/8)*8-1:0]           rsp_tdata,   // result_value
   input  logic                                 csr_we,
   input  logic [rsa_mexp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [WIDTH-1:0]                     csr_wdata
);
   import rsa_mexp_pkg::*;

   localparam int DATA_W = ((WIDTH + 7) / 8) * 8;
   localparam int RES_W  = (WIDTH < RESULT_MAX_W) ? WIDTH : RESULT_MAX_W;
   localparam int CNT_W  = $clog2(WIDTH + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SQR  = 2'd1;
   localparam logic [1:0] S_MUL  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [WIDTH-1:0]  modulus_ff, pub_exp_ff, priv_exp_ff;
   logic [WIDTH-1:0]  acc_ff, acc_in;
   logic [WIDTH-1:0]  base_ff, base_in;
   logic [WIDTH-1:0]  exp_ff, exp_in;
   logic [CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic              start_ff, start_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [WIDTH-1:0]  mul_b;
   logic [WIDTH-1:0]  product;
   mul_status_type    mul_st;
   logic              req_fire;
   logic              last_bit;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign last_bit   = (bit_cnt_ff == CNT_W'(1));
   assign mul_b      = (state_ff == S_MUL) ? base_ff : acc_ff;

   rsa_mexp_modmul #(.WIDTH(WIDTH)) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .a       (acc_ff),
      .b       (mul_b),
      .n       (modulus_ff),
      .status  (mul_st),
      .product (product)
   );

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      bit_cnt_in   = bit_cnt_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               base_in    = req_tdata[WIDTH-1:0];
               exp_in     = (req_tuser == OP_DECRYPT) ? priv_exp_ff : pub_exp_ff;
               bit_cnt_in = CNT_W'(WIDTH);
               acc_in     = (modulus_ff == WIDTH'(1)) ? '0 : WIDTH'(1);
               if (modulus_ff == '0) begin
                  acc_in   = '0;
                  state_in = S_OUT;
               end else begin
                  start_in = 1'b1;
                  state_in = S_SQR;
               end
            end
         end
         S_SQR: begin
            if (mul_st.done && !mul_st.busy) begin
               acc_in = product;
               if (exp_ff[WIDTH-1]) begin
                  start_in = 1'b1;
                  state_in = S_MUL;
               end else begin
                  exp_in     = {exp_ff[WIDTH-2:0], 1'b0};
                  bit_cnt_in = bit_cnt_ff - 1'b1;
                  if (last_bit) begin
                     state_in = S_OUT;
                  end else begin
                     start_in = 1'b1;
                  end
               end
            end
         end
         S_MUL: begin
            if (mul_st.done && !mul_st.busy) begin
               acc_in     = product;
               exp_in     = {exp_ff[WIDTH-2:0], 1'b0};
               bit_cnt_in = bit_cnt_ff - 1'b1;
               if (last_bit) begin
                  state_in = S_OUT;
               end else begin
                  start_in = 1'b1;
                  state_in = S_SQR;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = DATA_W'(acc_ff[RES_W-1:0]);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      exp_ff      <= exp_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         bit_cnt_ff   <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= WIDTH'(1);
         pub_exp_ff   <= '0;
         priv_exp_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_MODULUS:          modulus_ff  <= csr_wdata;
               CSR_PUBLIC_EXPONENT:  pub_exp_ff  <= csr_wdata;
               CSR_PRIVATE_EXPONENT: priv_exp_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/core/rsa_mexp_checker.sv
// Port-level checks for the modular exponentiation core, bound to the top level.
// Depends on assert_macros.svh and rsa_mexp_pkg.
`include "assert_macros.svh"

module rsa_mexp_checker #(
   parameter int WIDTH = 32
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [((WIDTH+7)/8)*8-1:0]          req_tdata,
   input logic                                req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [((WIDTH+7)/8)*8-1:0]          rsp_tdata,
   input logic                                csr_we,
   input logic [rsa_mexp_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [WIDTH-1:0]                    csr_wdata
);
   import rsa_mexp_pkg::*;

   logic req_fire;
   assign req_fire = req_tvalid && req_tready;

   // held response keeps its data
   `ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata),
                "response changed while stalled")

   // waiting request keeps its fields
   `ASSERT_NEXT(a_req_hold, req_tvalid && !req_tready,
                (req_tvalid && $stable(req_tdata) && $stable(req_tuser)),
                "request changed while waiting")

   // one item at a time: busy right after an accept
   `ASSERT_NEXT(a_busy_after_accept, req_fire, !req_tready,
                "request taken while an item is in progress")

   // no result appears in the cycle after an accept
   `ASSERT_NEXT(a_no_instant_rsp, req_fire, !$rose(rsp_tvalid),
                "response appeared too early")

   // registers change only while nothing is in flight
   `ASSERT_SAME(a_csr_idle, csr_we,
                (req_tready && !rsp_tvalid && !$isunknown({csr_index, csr_wdata})),
                "register written while an item is in flight")

endmodule

bind rsa_modular_exponentiation_core rsa_mexp_checker #(.WIDTH(WIDTH)) u_rsa_mexp_checker (.*);

// File: tb/rsa_mexp_result_checker.sv
// Result checker for the modular exponentiation core: tracks register writes,
// predicts each response from accepted requests and compares them in order.
// Depends on rsa_mexp_pkg.
`timescale 1ns / 100ps

module rsa_mexp_result_checker #(
   parameter int WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [((WIDTH+7)/8)*8-1:0]          req_tdata,   // [WIDTH-1:0] message_value
   input  logic                                req_tuser,   // [0] op
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [((WIDTH+7)/8)*8-1:0]          rsp_tdata,   // result_value
   input  logic                                csr_we,
   input  logic [rsa_mexp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [WIDTH-1:0]                    csr_wdata,
   output int                                  error_count,
   output int                                  results_pending
);
   import rsa_mexp_pkg::*;

   localparam int DATA_W = ((WIDTH+7)/8)*8;
   localparam int WIDE_W = 2*WIDTH;

   logic [WIDTH-1:0]  modulus_q;
   logic [WIDTH-1:0]  public_exp_q;
   logic [WIDTH-1:0]  private_exp_q;
   logic [DATA_W-1:0] expected_results[$];

   // square and multiply, every product reduced at once
   function automatic logic [DATA_W-1:0] mod_power(input logic [WIDTH-1:0] base,
                                                   input logic [WIDTH-1:0] power,
                                                   input logic [WIDTH-1:0] n);
      logic [WIDE_W-1:0] acc;
      logic [WIDE_W-1:0] base_red;
      logic [WIDE_W-1:0] n_wide;
      int                bit_idx;
      if (n == '0)
         return '0;
      n_wide   = WIDE_W'(n);
      base_red = WIDE_W'(base) % n_wide;
      acc      = WIDE_W'(1) % n_wide;
      for (bit_idx = WIDTH-1; bit_idx >= 0; bit_idx--) begin
         acc = (acc * acc) % n_wide;
         if (power[bit_idx])
            acc = (acc * base_red) % n_wide;
      end
      return DATA_W'(acc[WIDTH-1:0]);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         modulus_q     = 1;
         public_exp_q  = '0;
         private_exp_q = '0;
         expected_results.delete();
         error_count     <= 0;
         results_pending <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MODULUS:          modulus_q     = csr_wdata;
               CSR_PUBLIC_EXPONENT:  public_exp_q  = csr_wdata;
               CSR_PRIVATE_EXPONENT: private_exp_q = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result_value: no item expected, actual %h", rsp_tdata);
               error_count <= error_count + 1;
            end else if (rsp_tdata !== expected_results[0]) begin
               $error("result_value: expected %h, actual %h", expected_results[0], rsp_tdata);
               error_count <= error_count + 1;
               void'(expected_results.pop_front());
            end else begin
               void'(expected_results.pop_front());
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(mod_power(req_tdata[WIDTH-1:0],
               (req_tuser == OP_DECRYPT) ? private_exp_q : public_exp_q, modulus_q));
         results_pending <= expected_results.size();
      end
   end

endmodule

// File: tb/tb_top.sv
// Testbench top for the modular exponentiation core: clock, reset, register
// loads, request and response traffic, and the verdict.
// Depends on rsa_mexp_pkg, rsa_modular_exponentiation_core and rsa_mexp_result_checker.
`timescale 1ns / 100ps

module tb_top;
   import rsa_mexp_pkg::*;

   localparam int WIDTH  = 32;
   localparam int DATA_W = ((WIDTH+7)/8)*8;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int RANDOM_PHASES   = 7;
   localparam int ITEMS_PER_PHASE = 40;
   localparam int DRAIN_CYCLES    = 2200;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata;    // [WIDTH-1:0] message_value
   logic                  req_tuser;    // [0] op
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [DATA_W-1:0]     rsp_tdata;    // result_value
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [WIDTH-1:0]      csr_wdata;
   int                    error_count;
   int                    results_pending;
   bit                    no_gaps;
   logic [WIDTH-1:0]      modulus_now;

   rsa_modular_exponentiation_core #(.WIDTH(WIDTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   rsa_mexp_result_checker #(.WIDTH(WIDTH)) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .error_count     (error_count),
      .results_pending (results_pending)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_request(input logic op, input logic [WIDTH-1:0] message);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'(message);
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (results_pending != 0)
         @(negedge clock);
   endtask

   task automatic load_register(input logic [CSR_IDX_W-1:0] index,
                                input logic [WIDTH-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == CSR_MODULUS)
         modulus_now = value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_key(input logic [WIDTH-1:0] n, input logic [WIDTH-1:0] e,
                           input logic [WIDTH-1:0] d);
      load_register(CSR_MODULUS, n);
      load_register(CSR_PUBLIC_EXPONENT, e);
      load_register(CSR_PRIVATE_EXPONENT, d);
   endtask

   function automatic logic [WIDTH-1:0] pick_exponent();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return WIDTH'($urandom_range(1, 255));
         default: return WIDTH'($urandom);
      endcase
   endfunction

   // response side: random stall before each item, none in gap-free phases
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   initial begin
      int               phase;
      int               item_idx;
      logic [WIDTH-1:0] n;
      logic [WIDTH-1:0] message;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_ENCRYPT;
      csr_we      = 1'b0;
      csr_index   = CSR_MODULUS;
      csr_wdata   = '0;
      no_gaps     = 1'b0;
      modulus_now = 1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset key: modulus 1, zero exponents
      send_request(OP_ENCRYPT, '0);
      send_request(OP_DECRYPT, '1);
      drain_results();

      // textbook key, round trip, base at or above n
      load_key(32'd3233, 32'd17, 32'd2753);
      load_register(CSR_UNMAPPED, WIDTH'($urandom));
      send_request(OP_ENCRYPT, 32'd65);
      send_request(OP_DECRYPT, 32'd2790);
      send_request(OP_ENCRYPT, 32'd3233);
      send_request(OP_DECRYPT, '1);
      send_request(OP_ENCRYPT, '0);
      send_request(OP_DECRYPT, 32'd3232);
      drain_results();

      // widest modulus, all-ones public exponent, zero private exponent
      load_key('1, '1, '0);
      send_request(OP_ENCRYPT, '1);
      send_request(OP_ENCRYPT, 32'hFFFF_FFFE);
      send_request(OP_DECRYPT, 32'd12345);
      send_request(OP_DECRYPT, '0);
      drain_results();

      // modulus of zero
      load_register(CSR_MODULUS, '0);
      send_request(OP_ENCRYPT, '1);
      send_request(OP_DECRYPT, 32'h8000_0001);
      drain_results();

      load_key(32'd2, 32'd1, '1);
      send_request(OP_ENCRYPT, 32'd7);
      send_request(OP_DECRYPT, 32'd6);
      send_request(OP_DECRYPT, 32'd1);
      drain_results();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 9))
            0:       n = 1;
            1:       n = '1;
            2, 3:    n = WIDTH'($urandom_range(2, 65535));
            default: n = WIDTH'($urandom);
         endcase
         load_key(n, pick_exponent(), pick_exponent());
         if ($urandom_range(0, 2) == 0)
            load_register(CSR_UNMAPPED, WIDTH'($urandom));
         no_gaps = (phase == 2);
         for (item_idx = 0; item_idx < ITEMS_PER_PHASE; item_idx++) begin
            case ($urandom_range(0, 9))
               0:       message = '0;
               1:       message = modulus_now - 1;
               2, 3:    message = (modulus_now == 0) ? WIDTH'($urandom)
                                                     : WIDTH'($urandom) % modulus_now;
               default: message = WIDTH'($urandom);
            endcase
            send_request($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT, message);
         end
         drain_results();
      end
      no_gaps = 1'b0;

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && results_pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #70_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
